// ===== rtl/core/tspa_pkg.sv =====
package tspa_pkg;

    // Width of one power reading and of one average
    localparam int SAMPLE_W = 16;

    // Default averaging depths
    localparam int BLOCK_LEN_DEF = 8;
    localparam int SUM_DEPTH_DEF = 8;

    // Reset value of the forward limit
    localparam logic [SAMPLE_W-1:0] FWD_LIMIT_RST = 16'd1000;

    // Per-stage load strobes shared by both channels
    typedef struct packed {
        logic accept;   // stage A: request taken, shift sample line
        logic en_b;     // stage B: load block-sum product
        logic en_c;     // stage C: item moves into quotient stage
        logic wrap_c;   // item entering stage C closes a block
        logic en_d;     // stage D: load average product
    } stage_ctl_t;

endpackage

// ===== rtl/core/two_stage_power_averager_core.sv =====
// Two-stage power averager for a forward and a reflected power channel. Each
// request carries one reading per channel and returns one result with both
// averages and a forward warning. Every BLOCK_LEN-th reading closes a block;
// the average is the sum of the last SUM_DEPTH truncated block means, divided
// by SUM_DEPTH and truncated, with all history zero after reset. The core
// takes one request per clock while the result side does not stall; each
// request runs through a sample stage, a block-division multiply, a quotient
// accumulate, an average-division multiply and the result register. A stall
// on the result side holds the whole pipeline. The forward limit resets to
// 1000 and is rewritten through cfg_we / cfg_wdata, which the user must do
// only while the core is idle; the core itself does not enforce this.
module two_stage_power_averager_core #(
    parameter int BLOCK_LEN = tspa_pkg::BLOCK_LEN_DEF,
    parameter int SUM_DEPTH = tspa_pkg::SUM_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,   // forward_limit
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,     // [15:0] forward_sample, [31:16] reflected_sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata      // [15:0] forward_average,
                                     // [31:16] reflected_average,
                                     // [32] forward_warning, [39:33] zero
);

    localparam int SW    = tspa_pkg::SAMPLE_W;
    localparam int CNT_W = $clog2(BLOCK_LEN);
    localparam logic [CNT_W-1:0] POS_LAST = CNT_W'(BLOCK_LEN - 1);

    logic                 adv;
    logic                 s_accept;
    logic                 wrap_in;
    logic [CNT_W-1:0]     pos_reg;
    logic [CNT_W-1:0]     pos_next;
    logic                 a_valid_reg;
    logic                 a_wrap_reg;
    logic                 b_valid_reg;
    logic                 b_wrap_reg;
    logic                 c_valid_reg;
    logic                 d_valid_reg;
    logic                 m_valid_reg;
    logic [SW-1:0]        m_fwd_reg;
    logic [SW-1:0]        m_ref_reg;
    logic                 m_warn_reg;
    logic [SW-1:0]        limit_reg;
    logic [SW-1:0]        fwd_avg;
    logic [SW-1:0]        ref_avg;
    tspa_pkg::stage_ctl_t ctl;

    // Pipeline moves whenever the result register is free or drained
    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;
    assign s_accept = s_tvalid && adv;
    assign wrap_in  = (pos_reg == POS_LAST);
    assign pos_next = wrap_in ? '0 : pos_reg + CNT_W'(1);

    // Hold the forward limit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= tspa_pkg::FWD_LIMIT_RST;
        end else if (cfg_we) begin
            limit_reg <= cfg_wdata;
        end
    end

    // Advance the position inside the current block
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (s_accept) begin
            pos_reg <= pos_next;
        end
    end

    // Stage valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= s_tvalid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            m_valid_reg <= d_valid_reg;
        end
    end

    // Carry the block-close flag alongside the request
    always_ff @(posedge aclk) begin
        if (adv) begin
            a_wrap_reg <= wrap_in;
            b_wrap_reg <= a_wrap_reg;
        end
    end

    always_comb begin
        ctl.accept  = s_accept;
        ctl.en_b    = adv && a_valid_reg;
        ctl.en_c    = adv && b_valid_reg;
        ctl.wrap_c  = b_wrap_reg;
        ctl.en_d    = adv && c_valid_reg;
    end

    tspa_chan #(
        .BLOCK_LEN (BLOCK_LEN),
        .SUM_DEPTH (SUM_DEPTH)
    ) u_fwd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .sample  (s_tdata[15:0]),
        .average (fwd_avg)
    );

    tspa_chan #(
        .BLOCK_LEN (BLOCK_LEN),
        .SUM_DEPTH (SUM_DEPTH)
    ) u_ref (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .sample  (s_tdata[31:16]),
        .average (ref_avg)
    );

    // Load the result register and flag a forward overrange
    always_ff @(posedge aclk) begin
        if (adv && d_valid_reg) begin
            m_fwd_reg  <= fwd_avg;
            m_ref_reg  <= ref_avg;
            m_warn_reg <= (fwd_avg > limit_reg);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_warn_reg, m_ref_reg, m_fwd_reg};

    // Block position wraps after its last slot
    a_pos_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && wrap_in) |=> (pos_reg == '0))
        else $error("block position did not wrap");

    // Accepted request occupies stage A next cycle
    a_stage_a: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> a_valid_reg)
        else $error("accepted request lost at stage A");

    // Block-close flag follows its request into stage B
    a_wrap_carry: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && a_valid_reg && a_wrap_reg) |=> (b_valid_reg && b_wrap_reg))
        else $error("block-close flag lost between stages");

    // Item leaving stage D becomes a result
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && d_valid_reg) |=> m_valid_reg)
        else $error("finished item did not reach the result register");

endmodule

// ===== rtl/core/tspa_chan.sv =====
module tspa_chan #(
    parameter int BLOCK_LEN = tspa_pkg::BLOCK_LEN_DEF,
    parameter int SUM_DEPTH = tspa_pkg::SUM_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tspa_pkg::stage_ctl_t          ctl,
    input  logic [tspa_pkg::SAMPLE_W-1:0] sample,
    output logic [tspa_pkg::SAMPLE_W-1:0] average
);

    localparam int SW = tspa_pkg::SAMPLE_W;

    // Block sum: up to BLOCK_LEN full-scale readings
    localparam int BL_LOG  = $clog2(BLOCK_LEN);
    localparam int TW      = SW + BL_LOG;
    localparam int B_SHIFT = TW + BL_LOG;
    localparam int B_MUL_W = TW + 2;
    localparam logic [B_MUL_W-1:0] B_MUL =
        B_MUL_W'(((64'd1 << B_SHIFT) / BLOCK_LEN) + 64'd1);
    localparam int B_PROD_W = TW + B_MUL_W;

    // Quotient total: up to SUM_DEPTH full-scale quotients
    localparam int SD_LOG  = $clog2(SUM_DEPTH);
    localparam int QW      = SW + SD_LOG;
    localparam int D_SHIFT = QW + SD_LOG;
    localparam int D_MUL_W = QW + 2;
    localparam logic [D_MUL_W-1:0] D_MUL =
        D_MUL_W'(((64'd1 << D_SHIFT) / SUM_DEPTH) + 64'd1);
    localparam int D_PROD_W = QW + D_MUL_W;

    logic [SW-1:0]       smp_reg [BLOCK_LEN];
    logic [TW-1:0]       tot_reg;
    logic [TW-1:0]       tot_next;
    logic [TW-1:0]       a_total_reg;
    logic [B_PROD_W-1:0] b_prod_reg;
    logic [SW-1:0]       q_new;
    logic [SW-1:0]       qline_reg [SUM_DEPTH];
    logic [QW-1:0]       qtot_reg;
    logic [QW-1:0]       qtot_next;
    logic [D_PROD_W-1:0] d_prod_reg;

    // Running sum of the last BLOCK_LEN readings
    assign tot_next = tot_reg + TW'(sample) - TW'(smp_reg[BLOCK_LEN-1]);

    // Advance the sample line and its running sum
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < BLOCK_LEN; i++) begin
                smp_reg[i] <= '0;
            end
            tot_reg <= '0;
        end else if (ctl.accept) begin
            smp_reg[0] <= sample;
            for (int i = 1; i < BLOCK_LEN; i++) begin
                smp_reg[i] <= smp_reg[i-1];
            end
            tot_reg <= tot_next;
        end
    end

    // Hold the block sum seen before this reading enters
    always_ff @(posedge aclk) begin
        if (ctl.accept) begin
            a_total_reg <= tot_reg;
        end
    end

    // Divide the block sum by BLOCK_LEN through its reciprocal
    always_ff @(posedge aclk) begin
        if (ctl.en_b) begin
            b_prod_reg <= B_PROD_W'(a_total_reg) * B_PROD_W'(B_MUL);
        end
    end

    assign q_new     = b_prod_reg[B_SHIFT +: SW];
    assign qtot_next = qtot_reg + QW'(q_new) - QW'(qline_reg[SUM_DEPTH-1]);

    // Retire the oldest block quotient and take in the new one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SUM_DEPTH; i++) begin
                qline_reg[i] <= '0;
            end
            qtot_reg <= '0;
        end else if (ctl.en_c && ctl.wrap_c) begin
            qline_reg[0] <= q_new;
            for (int i = 1; i < SUM_DEPTH; i++) begin
                qline_reg[i] <= qline_reg[i-1];
            end
            qtot_reg <= qtot_next;
        end
    end

    // Divide the quotient total by SUM_DEPTH through its reciprocal
    always_ff @(posedge aclk) begin
        if (ctl.en_d) begin
            d_prod_reg <= D_PROD_W'(qtot_reg) * D_PROD_W'(D_MUL);
        end
    end

    assign average = d_prod_reg[D_SHIFT +: SW];

endmodule
